/* src/binary_lifting_lca_top_macros.svh */
// Assertion helpers for the binary lifting LCA block.
// Both macros check on the rising edge of clk and are idle while rst is high.
`ifndef BINARY_LIFTING_LCA_TOP_MACROS_SVH
`define BINARY_LIFTING_LCA_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define BLCA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define BLCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BLCA_ASSERT_NOW(label, ante, cons, msg)
`define BLCA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* src/blca_pkg.sv */
`default_nettype none

package blca_pkg;

  localparam int NODES   = 1024;
  localparam int LEVELS  = 11;
  localparam int NODE_W  = $clog2(NODES + 1);
  localparam int DEPTH_W = $clog2(NODES);
  localparam int LVL_W   = $clog2(LEVELS);

  // Operation codes on the func field
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [LVL_W-1:0]   lvl_t;
  typedef logic [LEVELS-1:0]  diff_t;

  // One node's row: depth plus an ancestor for every jump level
  typedef logic [LEVELS-1:0][NODE_W-1:0] jump_row_t;
  typedef struct packed {
    depth_t    depth;
    jump_row_t jump;
  } entry_t;

  localparam int     ENTRY_W   = $bits(entry_t);
  localparam lvl_t   LVL_LAST  = lvl_t'(LEVELS - 1);
  localparam depth_t DEPTH_MAX = depth_t'(NODES - 1);
  localparam node_t  NODE_LAST = node_t'(NODES);

  typedef enum logic [15:0] {
    S_CLEAR     = 16'h0001,
    S_IDLE      = 16'h0002,
    S_ADD_DEP   = 16'h0004,
    S_ADD_STEP  = 16'h0008,
    S_ADD_WAIT  = 16'h0010,
    S_ADD_WRITE = 16'h0020,
    S_Q_LOAD    = 16'h0040,
    S_Q_ORDER   = 16'h0080,
    S_Q_LIFT    = 16'h0100,
    S_Q_LIFT_W  = 16'h0200,
    S_Q_CHK_W   = 16'h0400,
    S_Q_CHK     = 16'h0800,
    S_Q_CLIMB   = 16'h1000,
    S_Q_CLIMB_W = 16'h2000,
    S_Q_ANS_W   = 16'h4000,
    S_Q_ANS     = 16'h8000
  } state_t;

  // Node numbers above the node count fold onto the sentinel
  function automatic node_t clip_node(input node_t x);
    return (x > NODE_LAST) ? '0 : x;
  endfunction

endpackage

`default_nettype wire

/* src/blca_ram.sv */
`default_nettype none

module blca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  output logic      [WIDTH-1:0]         rdata0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

/* src/binary_lifting_lca_top.sv */
// Channel | Signals                                   | Direction | Transaction
// --------+-------------------------------------------+-----------+--------------------------
// in      | in_valid, in_ready, func, first_node,     | in        | add a node, or query LCA
//         | second_node                               |           |
// out     | out_valid, out_ready, ancestor            | out       | one per query, none per add
//
// After reset all NODES+1 rows of the node table are swept to zero, with in_ready low.
// An add does one table read for each jump level above level 0, then one row write.
// In a query every jump costs one read of the single node table (registered read),
// during the lift and during the top-down climb.
// One transaction is worked on at a time; in_ready is high only while idle.
// The result sits in an output register, so a stalled out channel holds only a
// following query at its last step.
`default_nettype none
`include "binary_lifting_lca_top_macros.svh"

module binary_lifting_lca_top
  import blca_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire logic  func,
  input  wire node_t first_node,
  input  wire node_t second_node,
  output logic       out_valid,
  input  wire logic  out_ready,
  output node_t      ancestor
);

  state_t    state;
  node_t     clr;
  node_t     a;
  node_t     b;
  node_t     u;
  lvl_t      lvl;
  diff_t     diff;
  depth_t    dep;
  jump_row_t row;

  logic   ram_we;
  node_t  ram_waddr;
  entry_t ram_wdata;
  logic [ENTRY_W-1:0] rdata0;
  logic [ENTRY_W-1:0] rdata1;
  entry_t q0;
  entry_t q1;

  logic  slot_free;
  node_t step_val;
  logic  lift_bit;
  logic  climb_diff;
  logic  result_load;

  // Node table: one row per node, read at a and b
  blca_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODES + 1)
  ) u_table (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr0 (a),
    .rdata0 (rdata0),
    .raddr1 (b),
    .rdata1 (rdata1)
  );

  assign q0 = rdata0;
  assign q1 = rdata1;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  // Next jump for the row being built; a jump onto the node itself uses the new row
  assign step_val   = (a == u) ? a : q0.jump[lvl - lvl_t'(1)];
  assign lift_bit   = diff[lvl];
  assign climb_diff = (q0.jump[lvl] != q1.jump[lvl]);

  // A query's answer goes into the output register this cycle
  assign result_load = slot_free &&
                       (((state == S_Q_CHK) && (a == b)) ||
                        ((state == S_Q_CLIMB) && !climb_diff && (lvl == '0)) ||
                        (state == S_Q_ANS));

  // Table write: clearing sweep, or the finished row of an add
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = u;
    ram_wdata = '{depth: dep, jump: row};
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr;
      ram_wdata = '0;
    end else if (state == S_ADD_WRITE) begin
      ram_we = 1'b1;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      lvl       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr == NODE_LAST) begin
            state <= S_IDLE;
          end else begin
            clr <= clr + node_t'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            if (func == FUNC_QUERY) begin
              a     <= clip_node(first_node);
              b     <= clip_node(second_node);
              state <= S_Q_LOAD;
            end else if (clip_node(first_node) != '0) begin
              u     <= clip_node(first_node);
              a     <= clip_node(second_node);
              state <= S_ADD_DEP;
            end
          end
        end
        // Parent row read in flight; first jump is the parent itself
        S_ADD_DEP: begin
          row[0] <= a;
          lvl    <= lvl_t'(1);
          state  <= S_ADD_STEP;
        end
        S_ADD_STEP: begin
          // First step: parent row is on the read port, take its depth
          if (lvl == lvl_t'(1)) begin
            if (a == '0) begin
              dep <= '0;
            end else if (q0.depth >= DEPTH_MAX) begin
              dep <= DEPTH_MAX;
            end else begin
              dep <= q0.depth + depth_t'(1);
            end
          end
          row[lvl] <= step_val;
          a        <= step_val;
          if (lvl == LVL_LAST) begin
            state <= S_ADD_WRITE;
          end else begin
            lvl   <= lvl + lvl_t'(1);
            state <= S_ADD_WAIT;
          end
        end
        S_ADD_WAIT: begin
          state <= S_ADD_STEP;
        end
        S_ADD_WRITE: begin
          state <= S_IDLE;
        end
        S_Q_LOAD: begin
          state <= S_Q_ORDER;
        end
        // Deeper node goes to a
        S_Q_ORDER: begin
          if (q0.depth < q1.depth) begin
            a     <= b;
            b     <= a;
            state <= S_Q_LOAD;
          end else begin
            diff  <= diff_t'(q0.depth - q1.depth);
            lvl   <= '0;
            state <= S_Q_LIFT;
          end
        end
        // Lift a by the depth difference, one level per step
        S_Q_LIFT: begin
          if (lift_bit) begin
            a <= q0.jump[lvl];
          end
          if (lvl == LVL_LAST) begin
            state <= lift_bit ? S_Q_CHK_W : S_Q_CHK;
          end else begin
            lvl   <= lvl + lvl_t'(1);
            state <= lift_bit ? S_Q_LIFT_W : S_Q_LIFT;
          end
        end
        S_Q_LIFT_W: begin
          state <= S_Q_LIFT;
        end
        S_Q_CHK_W: begin
          state <= S_Q_CHK;
        end
        S_Q_CHK: begin
          if (a == b) begin
            if (slot_free) begin
              ancestor <= a;
              state    <= S_IDLE;
            end
          end else begin
            lvl   <= LVL_LAST;
            state <= S_Q_CLIMB;
          end
        end
        // Climb both nodes from the top level down
        S_Q_CLIMB: begin
          if (climb_diff) begin
            a <= q0.jump[lvl];
            b <= q1.jump[lvl];
            if (lvl == '0) begin
              state <= S_Q_ANS_W;
            end else begin
              lvl   <= lvl - lvl_t'(1);
              state <= S_Q_CLIMB_W;
            end
          end else if (lvl == '0) begin
            if (slot_free) begin
              ancestor <= q0.jump[0];
              state    <= S_IDLE;
            end
          end else begin
            lvl <= lvl - lvl_t'(1);
          end
        end
        S_Q_CLIMB_W: begin
          state <= S_Q_CLIMB;
        end
        S_Q_ANS_W: begin
          state <= S_Q_ANS;
        end
        S_Q_ANS: begin
          if (slot_free) begin
            ancestor <= q0.jump[0];
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Sentinel row stays zero once the sweep is over
  `BLCA_ASSERT_NOW(a_sentinel_kept, ram_we, (state == S_CLEAR) || (ram_waddr != '0),
                   "sentinel row overwritten")
  // A result only comes out of a query's final steps
  `BLCA_ASSERT_NOW(a_result_source, $rose(out_valid),
                   ($past(state) == S_Q_CHK) || ($past(state) == S_Q_CLIMB) ||
                   ($past(state) == S_Q_ANS), "result without query")
  // An add of the sentinel node is dropped
  `BLCA_ASSERT_NEXT(a_null_add,
                    in_valid && in_ready && (func == FUNC_ADD) && (clip_node(first_node) == '0),
                    state == S_IDLE, "add of node zero not dropped")

endmodule

`default_nettype wire

/* tb/sv/binary_lifting_lca_top_test.sv */
`default_nettype none

module binary_lifting_lca_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import blca_pkg::*;

  localparam int STALL_LIMIT = 6000;  // clear sweep plus the long receiver hold, with margin
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 120;

  typedef struct {
    logic  op;
    node_t a;
    node_t b;
  } lca_job_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  logic  func = FUNC_ADD;
  node_t first_node = '0;
  node_t second_node = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  node_t ancestor;

  // Stimulus, expectations and idling controls
  lca_job_t pending_jobs[$];
  node_t    expected_anc[$];
  int       send_gap_pct = 0;
  int       recv_gap_pct = 0;
  logic     hold_req = 1'b0;
  logic     hold_used = 1'b0;
  int       hold_left = 0;
  int       fault_count = 0;
  int       quiet_cycles = 0;

  // Predictor state: ancestor 2^k levels up, and depth, per node
  node_t  lift_tab [LEVELS][NODES+1];
  depth_t level_of [NODES+1];

  binary_lifting_lca_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .first_node  (first_node),
    .second_node (second_node),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ancestor    (ancestor)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Record a node under its parent and fill its jump row
  function automatic void record_node(node_t u, node_t p);
    int d;
    int k;
    if (u == '0) return;
    d = (p == '0) ? 0 : int'(level_of[p]) + 1;
    if (d > NODES - 1) d = NODES - 1;
    level_of[u] = depth_t'(d);
    lift_tab[0][u] = p;
    for (k = 1; k < LEVELS; k++) lift_tab[k][u] = lift_tab[k-1][lift_tab[k-1][u]];
  endfunction

  // Lift the deeper node, then climb both from the top level down
  function automatic node_t common_ancestor(node_t a, node_t b);
    node_t t;
    int    gap;
    int    k;
    if (level_of[a] < level_of[b]) begin
      t = a;
      a = b;
      b = t;
    end
    gap = int'(level_of[a]) - int'(level_of[b]);
    for (k = 0; k < LEVELS; k++) if (gap[k]) a = lift_tab[k][a];
    if (a == b) return a;
    for (k = LEVELS - 1; k >= 0; k--) begin
      if (lift_tab[k][a] != lift_tab[k][b]) begin
        a = lift_tab[k][a];
        b = lift_tab[k][b];
      end
    end
    return lift_tab[0][a];
  endfunction

  // Apply one accepted transaction; out-of-range numbers fold to the sentinel
  function automatic void take_item(logic op, node_t a, node_t b);
    node_t ua;
    node_t ub;
    ua = (a > node_t'(NODES)) ? '0 : a;
    ub = (b > node_t'(NODES)) ? '0 : b;
    if (op == FUNC_ADD) record_node(ua, ub);
    else expected_anc.push_back(common_ancestor(ua, ub));
  endfunction

  function automatic void report(string msg);
    fault_count++;
    if (fault_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endfunction

  function automatic void check_answer(node_t got);
    node_t want;
    if (expected_anc.size() == 0) begin
      report($sformatf("ancestor %0d with no query outstanding", got));
    end else begin
      want = expected_anc.pop_front();
      if (got !== want) report($sformatf("ancestor expected %0d, got %0d", want, got));
    end
  endfunction

  // Driver: predicts on acceptance, then offers the next pending transaction
  always @(posedge clk) begin : drive
    lca_job_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) take_item(func, first_node, second_node);
      if (!in_valid || in_ready) begin
        if (pending_jobs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          nxt = pending_jobs.pop_front();
          in_valid    <= 1'b1;
          func        <= nxt.op;
          first_node  <= nxt.a;
          second_node <= nxt.b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results and drives out_ready, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_answer(ancestor);
      if (hold_req && !hold_used) begin
        hold_used <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("binary_lifting_lca_top_test NOT OK");
        $finish;
      end
    end
  end

  task automatic queue_job(logic op, int a, int b);
    lca_job_t j;
    j.op = op;
    j.a  = node_t'(a);
    j.b  = node_t'(b);
    pending_jobs.push_back(j);
  endtask

  task automatic queue_add(int u, int p);
    queue_job(FUNC_ADD, u, p);
  endtask

  task automatic queue_query(int a, int b);
    queue_job(FUNC_QUERY, a, b);
  endtask

  task automatic wait_drained();
    while (pending_jobs.size() != 0 || in_valid || expected_anc.size() != 0) @(negedge clk);
  endtask

  // Random trees built parent first, queried, with some noise and broken links
  task automatic grow_forests(int budget);
    int made;
    int size;
    int n;
    int u;
    int p;
    int lo;
    int qn;
    int a;
    int b;
    int r;
    int members[$];
    bit taken [NODES+1];
    made = 0;
    while (made < budget) begin
      if ($urandom_range(99) < 10) begin
        queue_job(logic'($urandom_range(1)), $urandom_range(2047), $urandom_range(2047));
        made++;
      end else begin
        members.delete();
        size = ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(16, 2);
        for (n = 0; n < size; n++) begin
          do u = $urandom_range(NODES, 1); while (taken[u]);
          taken[u] = 1'b1;
          r = $urandom_range(99);
          if (n == 0 || r < 5) begin
            p = 0;
          end else if (r < 10) begin
            p = $urandom_range(NODES, 1);  // link to any node, possibly outside this tree
          end else if (r < 55) begin
            lo = (members.size() > 3) ? members.size() - 3 : 0;
            p = members[$urandom_range(members.size() - 1, lo)];
          end else begin
            p = members[$urandom_range(members.size() - 1)];
          end
          queue_add(u, p);
          members.push_back(u);
        end
        qn = $urandom_range(size + 2, 1);
        for (n = 0; n < qn; n++) begin
          a = members[$urandom_range(members.size() - 1)];
          b = ($urandom_range(99) < 8) ? $urandom_range(2047)
                                      : members[$urandom_range(members.size() - 1)];
          if ($urandom_range(1)) queue_query(a, b);
          else queue_query(b, a);
        end
        made += size + qn;
        foreach (members[i]) taken[members[i]] = 1'b0;
      end
    end
  endtask

  // Stimulus sequence
  initial begin
    int u;
    int a;
    int b;
    for (int k = 0; k < LEVELS; k++)
      for (int n = 0; n <= NODES; n++) lift_tab[k][n] = '0;
    for (int n = 0; n <= NODES; n++) level_of[n] = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Sender idles lightly, receiver heavily
    send_gap_pct = 15;
    recv_gap_pct = 48;

    // Directed: empty table, roots, folding, ignored adds, orphan parent, re-add
    queue_query(1, 2);
    queue_add(1, 0);
    queue_add(2, 1);
    queue_add(3, 1);
    queue_add(4, 2);
    queue_add(1024, 4);
    queue_add(5, 2047);
    queue_add(0, 1);
    queue_add(2047, 1);
    queue_add(6, 900);
    queue_query(4, 3);
    queue_query(1024, 3);
    queue_query(3, 1024);
    queue_query(1024, 4);
    queue_query(1, 1);
    queue_query(1024, 1024);
    queue_query(5, 1024);
    queue_query(2047, 4);
    queue_query(0, 1024);
    queue_query(6, 1024);
    queue_add(2, 3);
    queue_query(1024, 2);
    queue_query(2, 4);
    queue_query(1025, 1025);
    queue_add(7, 1025);
    grow_forests(200);
    wait_drained();

    // Roles swapped: deepest chain, long receiver hold, depth saturation
    send_gap_pct = 48;
    recv_gap_pct = 15;
    for (u = 1; u <= NODES; u++) queue_add(u, u - 1);
    wait_drained();
    hold_req = 1'b1;
    queue_query(1024, 2);
    queue_query(2, 1024);
    for (int n = 0; n < 60; n++) begin
      a = $urandom_range(NODES, 2);
      b = $urandom_range(NODES, 2);
      queue_query(a, b);
    end
    queue_add(1, 1024);
    queue_add(1023, 1024);
    queue_query(1, 1023);
    queue_query(1, 1024);
    queue_query(1023, 512);
    queue_query(1, 2);
    grow_forests(150);
    wait_drained();

    // No idling on either side
    send_gap_pct = 0;
    recv_gap_pct = 0;
    grow_forests(200);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && expected_anc.size() == 0) begin
      $display("binary_lifting_lca_top_test OK");
    end else begin
      $display("binary_lifting_lca_top_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
+incdir+src
src/blca_pkg.sv
src/blca_ram.sv
src/binary_lifting_lca_top.sv
tb/sv/binary_lifting_lca_top_test.sv
